### rtl/core/rtvm_pkg.sv
package rtvm_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_CHAR  = 2'd2;

   localparam logic [3:0] K_CHAR   = 4'd0;
   localparam logic [3:0] K_ANY    = 4'd1;
   localparam logic [3:0] K_SOL    = 4'd2;
   localparam logic [3:0] K_EOL    = 4'd3;
   localparam logic [3:0] K_CLASS  = 4'd4;
   localparam logic [3:0] K_NCLASS = 4'd5;
   localparam logic [3:0] K_BRANCH = 4'd6;
   localparam logic [3:0] K_JMP    = 4'd7;
   localparam logic [3:0] K_MATCH  = 4'd8;

   localparam logic [1:0] ST_SCAN   = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_END    = 2'd2;
   localparam logic [1:0] ST_IGNORE = 2'd3;

   localparam logic [2:0] CSR_CASE_INS  = 3'd0;
   localparam logic [2:0] CSR_MULTILINE = 3'd1;
   localparam logic [2:0] CSR_SEARCH    = 3'd2;
   localparam logic [2:0] CSR_STOP      = 3'd3;
   localparam logic [2:0] CSR_END_CHAR  = 3'd4;

   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] LETTER_SPAN  = 8'd25;
   localparam logic [7:0] CASE_DELTA   = 8'h20;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  instr_index;
      logic [3:0]  instr_kind;
      logic [7:0]  instr_char;
      logic [5:0]  instr_target_a;
      logic [5:0]  instr_target_b;
      logic [63:0] instr_class_chars;
      logic [7:0]  char_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] match_start_pos;
      logic [31:0] match_end_pos;
      logic [31:0] position;
   } rsp_type;

   typedef struct packed {
      logic       case_insensitive;
      logic       multiline;
      logic       search_mode;
      logic       stop_at_first;
      logic [7:0] end_char;
   } cfg_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] ch;
      logic [5:0] ta;
      logic [5:0] tb;
   } op_type;

   typedef enum logic [1:0] {
      IC_LOAD,
      IC_START,
      IC_CHAR,
      IC_IGNORE
   } item_class_type;

   typedef struct packed {
      item_class_type cls;
      req_type        req;
   } qent_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_SLOT  = 7'b0000100,
      S_EXEC  = 7'b0001000,
      S_BR2   = 7'b0010000,
      S_END   = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic ci);
      if (ci && c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + LETTER_SPAN)
         return c + CASE_DELTA;
      return c;
   endfunction

endpackage

### rtl/core/rtvm_ram.sv
module rtvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/core/rtvm_front.sv
module rtvm_front #(
   parameter int PROG_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rtvm_pkg::req_type  req_data,
   output logic               q_valid,
   input  logic               q_pop,
   output rtvm_pkg::qent_type q_data
);
   import rtvm_pkg::*;

   qent_type   buf_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;
   logic       push;
   qent_type   ent;

   always_comb begin
      ent.req = req_data;
      unique case (req_data.opcode)
         OP_LOAD:  ent.cls = (32'(req_data.instr_index) < PROG_DEPTH) ? IC_LOAD : IC_IGNORE;
         OP_START: ent.cls = IC_START;
         OP_CHAR:  ent.cls = IC_CHAR;
         default:  ent.cls = IC_IGNORE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wp_ff] <= ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (q_pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end
endmodule

### rtl/core/rtvm_back.sv
module rtvm_back #(
   parameter int PROG_DEPTH  = 64,
   parameter int CLASS_CHARS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  rtvm_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_pop,
   input  rtvm_pkg::qent_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rtvm_pkg::rsp_type  rsp_data
);
   import rtvm_pkg::*;

   localparam int AW = $clog2(PROG_DEPTH);
   localparam int CW = $clog2(PROG_DEPTH + 1);

   state_type             state_ff;
   logic                  sel_ff;
   logic [PROG_DEPTH-1:0] mark_ff [2];
   logic [CW-1:0]         cur_cnt_ff;
   logic [CW-1:0]         nxt_cnt_ff;
   logic [CW-1:0]         t_ff;
   logic [AW-1:0]         slot_ff;
   logic [AW-1:0]         tb_ff;
   logic [31:0]           pos_ff;
   logic [31:0]           attempt_ff;
   logic [31:0]           found_ff;
   logic [7:0]            prev_ff;
   logic [7:0]            prev_used_ff;
   logic [7:0]            char_ff;
   logic                  finished_ff;
   logic [1:0]            status_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [AW-1:0] wrap_tab [64];
   logic [AW-1:0] list_rd;
   logic [AW-1:0] list_rdata [2];
   logic          list_we [2];
   logic [AW-1:0] list_waddr [2];
   logic [AW-1:0] list_wdata [2];
   logic [23:0]   ops_rd;
   logic [63:0]   cls_rd;
   op_type        op;
   op_type        op_wr;
   logic          prog_we;
   logic [AW-1:0] slot_inc;
   logic          eq_ch;
   logic          cls_hit;
   logic          sol_ok;
   logic          eol_ok;
   logic          addc_req;
   logic          addc_fresh;
   logic [AW-1:0] addc_slot;
   logic          addn_req;
   logic [AW-1:0] addn_slot;
   logic          addc_ok;
   logic          addn_ok;

   for (genvar g = 0; g < 64; g++) begin : g_wrap
      assign wrap_tab[g] = AW'(g % PROG_DEPTH);
   end

   assign prog_we = (state_ff == S_IDLE) && q_valid && (q_data.cls == IC_LOAD);
   assign op_wr   = '{kind: q_data.req.instr_kind, ch: q_data.req.instr_char,
                      ta: q_data.req.instr_target_a, tb: q_data.req.instr_target_b};
   assign list_rd = sel_ff ? list_rdata[1] : list_rdata[0];

   rtvm_ram #(.WIDTH(24), .DEPTH(PROG_DEPTH)) u_ops (
      .clock(clock), .we(prog_we), .waddr(AW'(32'(q_data.req.instr_index))),
      .wdata(op_wr), .raddr(list_rd), .rdata(ops_rd)
   );

   rtvm_ram #(.WIDTH(64), .DEPTH(PROG_DEPTH)) u_cls (
      .clock(clock), .we(prog_we), .waddr(AW'(32'(q_data.req.instr_index))),
      .wdata(q_data.req.instr_class_chars), .raddr(list_rd), .rdata(cls_rd)
   );

   for (genvar b = 0; b < 2; b++) begin : g_list
      always_comb begin
         if (sel_ff == 1'(b)) begin
            list_we[b]    = addc_ok;
            list_waddr[b] = addc_fresh ? '0 : cur_cnt_ff[AW-1:0];
            list_wdata[b] = addc_slot;
         end else begin
            list_we[b]    = addn_ok;
            list_waddr[b] = nxt_cnt_ff[AW-1:0];
            list_wdata[b] = addn_slot;
         end
      end

      rtvm_ram #(.WIDTH(AW), .DEPTH(PROG_DEPTH)) u_list (
         .clock(clock), .we(list_we[b]), .waddr(list_waddr[b]),
         .wdata(list_wdata[b]), .raddr(t_ff[AW-1:0]), .rdata(list_rdata[b])
      );
   end

   assign op       = op_type'(ops_rd);
   assign slot_inc = (slot_ff == AW'(PROG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign eq_ch    = fold(char_ff, cfg.case_insensitive) == fold(op.ch, cfg.case_insensitive);
   assign sol_ok   = (pos_ff == 32'd1) || (cfg.multiline && prev_used_ff == CHAR_NL);
   assign eol_ok   = (char_ff == cfg.end_char) || (cfg.multiline && char_ff == CHAR_NL);

   // class bytes stop at the first zero byte
   always_comb begin
      logic       live;
      logic [7:0] cb;
      live    = 1'b1;
      cls_hit = 1'b0;
      for (int i = 0; i < CLASS_CHARS; i++) begin
         cb = cls_rd[8*i +: 8];
         if (cb == 8'd0) begin
            live = 1'b0;
         end
         if (live && fold(cb, cfg.case_insensitive) == fold(char_ff, cfg.case_insensitive)) begin
            cls_hit = 1'b1;
         end
      end
   end

   always_comb begin
      addc_req   = 1'b0;
      addc_fresh = 1'b0;
      addc_slot  = '0;
      addn_req   = 1'b0;
      addn_slot  = slot_inc;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && q_data.cls == IC_START) begin
               addc_req   = 1'b1;
               addc_fresh = 1'b1;
            end
         end
         S_EXEC: begin
            case (op.kind)
               K_CHAR:   addn_req = eq_ch;
               K_ANY:    addn_req = (char_ff != CHAR_NL);
               K_SOL: begin
                  addc_req  = sol_ok;
                  addc_slot = slot_inc;
               end
               K_EOL: begin
                  addc_req  = eol_ok;
                  addc_slot = slot_inc;
               end
               K_CLASS:  addn_req = cls_hit;
               K_NCLASS: addn_req = !cls_hit;
               K_BRANCH, K_JMP: begin
                  addc_req  = 1'b1;
                  addc_slot = wrap_tab[op.ta];
               end
               default: ;
            endcase
         end
         S_BR2: begin
            addc_req  = 1'b1;
            addc_slot = tb_ff;
         end
         S_END: begin
            if (char_ff != cfg.end_char && nxt_cnt_ff == '0 && cfg.search_mode
                && found_ff == 32'd0) begin
               addc_req   = 1'b1;
               addc_fresh = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign addc_ok = addc_req && (addc_fresh || (!mark_ff[sel_ff][addc_slot]
                    && cur_cnt_ff < CW'(PROG_DEPTH)));
   assign addn_ok = addn_req && !mark_ff[~sel_ff][addn_slot]
                    && nxt_cnt_ff < CW'(PROG_DEPTH);
   assign q_pop   = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 1'b0;
         mark_ff[0]   <= '0;
         mark_ff[1]   <= '0;
         cur_cnt_ff   <= '0;
         nxt_cnt_ff   <= '0;
         t_ff         <= '0;
         pos_ff       <= '0;
         attempt_ff   <= '0;
         found_ff     <= '0;
         prev_ff      <= '0;
         finished_ff  <= 1'b1;
         status_ff    <= ST_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  unique case (q_data.cls)
                     IC_LOAD: begin
                        status_ff <= ST_SCAN;
                        state_ff  <= S_RESP;
                     end
                     IC_START: begin
                        mark_ff[0]  <= '0;
                        mark_ff[1]  <= '0;
                        nxt_cnt_ff  <= '0;
                        pos_ff      <= '0;
                        prev_ff     <= '0;
                        attempt_ff  <= '0;
                        found_ff    <= '0;
                        finished_ff <= 1'b0;
                        status_ff   <= ST_SCAN;
                        state_ff    <= S_RESP;
                     end
                     IC_CHAR: begin
                        if (finished_ff) begin
                           status_ff <= ST_IGNORE;
                           state_ff  <= S_RESP;
                        end else begin
                           prev_used_ff <= prev_ff;
                           prev_ff      <= q_data.req.char_value;
                           char_ff      <= q_data.req.char_value;
                           if (pos_ff != '1) begin
                              pos_ff <= pos_ff + 32'd1;
                           end
                           t_ff     <= '0;
                           state_ff <= S_FETCH;
                        end
                     end
                     default: begin
                        status_ff <= ST_IGNORE;
                        state_ff  <= S_RESP;
                     end
                  endcase
               end
            end
            S_FETCH: begin
               state_ff <= (t_ff < cur_cnt_ff) ? S_SLOT : S_END;
            end
            S_SLOT: begin
               slot_ff  <= list_rd;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               tb_ff <= wrap_tab[op.tb];
               if (op.kind == K_MATCH) begin
                  found_ff <= pos_ff;
                  if (cfg.stop_at_first) begin
                     finished_ff <= 1'b1;
                     status_ff   <= ST_MATCH;
                     state_ff    <= S_RESP;
                  end else begin
                     t_ff     <= t_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
               end else if (op.kind == K_BRANCH) begin
                  state_ff <= S_BR2;
               end else begin
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= S_FETCH;
               end
            end
            S_BR2: begin
               t_ff     <= t_ff + 1'b1;
               state_ff <= S_FETCH;
            end
            S_END: begin
               if (char_ff == cfg.end_char) begin
                  finished_ff <= 1'b1;
                  status_ff   <= ST_END;
                  state_ff    <= S_RESP;
               end else if (nxt_cnt_ff == '0) begin
                  if (!cfg.search_mode || found_ff != 32'd0) begin
                     finished_ff <= 1'b1;
                     status_ff   <= ST_MATCH;
                     state_ff    <= S_RESP;
                  end else if (pos_ff - 32'd1 != attempt_ff) begin
                     // retry same char from slot 0
                     attempt_ff <= pos_ff - 32'd1;
                     t_ff       <= '0;
                     state_ff   <= S_FETCH;
                  end else begin
                     attempt_ff <= pos_ff;
                     status_ff  <= ST_SCAN;
                     state_ff   <= S_RESP;
                  end
               end else begin
                  sel_ff          <= ~sel_ff;
                  cur_cnt_ff      <= nxt_cnt_ff;
                  nxt_cnt_ff      <= '0;
                  mark_ff[sel_ff] <= '0;
                  status_ff       <= ST_SCAN;
                  state_ff        <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{status: status_ff, match_start_pos: attempt_ff,
                                    match_end_pos: found_ff, position: pos_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (addc_ok) begin
            if (addc_fresh) begin
               mark_ff[sel_ff] <= '0;
               cur_cnt_ff      <= CW'(1);
            end else begin
               cur_cnt_ff <= cur_cnt_ff + 1'b1;
            end
            mark_ff[sel_ff][addc_slot] <= 1'b1;
         end
         if (addn_ok) begin
            mark_ff[~sel_ff][addn_slot] <= 1'b1;
            nxt_cnt_ff                  <= nxt_cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

### rtl/core/regex_thread_vm_matcher.sv
// Thread-list regex matcher.
// req channel (req_valid/req_ready/req_data) takes one word per item: a program
// load, a start, or one input character. rsp channel (rsp_valid/rsp_ready/
// rsp_data) returns exactly one word per item, in order: status, attempt start,
// match end and position. csr_we/csr_index/csr_wdata write the mode registers
// (case fold, multiline, search, stop at first, end char); the user must write
// them only while idle, as the block itself does not enforce this. A two-entry
// queue holds classified words ahead of the sequencer. For a character the
// sequencer walks the current list through the list RAM and program RAM reads,
// with an extra state for the second target of a branch; a search retry walks
// the list again. Items are processed one at a time; the next word is taken by
// the sequencer as soon as the previous result sits in the output register.
// Reset clears the lists, marks and positions and leaves the block finished:
// characters are ignored until a start word. The program RAM is not cleared.
// When the receiver stalls, the result is held in the output register, the
// sequencer waits, and req_ready drops once the queue is full.
module regex_thread_vm_matcher #(
   parameter int PROG_DEPTH  = 64,
   parameter int CLASS_CHARS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtvm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtvm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import rtvm_pkg::*;

   cfg_type  cfg_ff;
   qent_type q_data;
   logic     q_valid;
   logic     q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CASE_INS:  cfg_ff.case_insensitive <= csr_wdata[0];
            CSR_MULTILINE: cfg_ff.multiline        <= csr_wdata[0];
            CSR_SEARCH:    cfg_ff.search_mode      <= csr_wdata[0];
            CSR_STOP:      cfg_ff.stop_at_first    <= csr_wdata[0];
            CSR_END_CHAR:  cfg_ff.end_char         <= csr_wdata;
            default: ;
         endcase
      end
   end

   rtvm_front #(.PROG_DEPTH(PROG_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
   );

   rtvm_back #(.PROG_DEPTH(PROG_DEPTH), .CLASS_CHARS(CLASS_CHARS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_end_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_END |-> rsp_data.position != 32'd0)
      else $error("end status with zero position");

   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.match_end_pos <= rsp_data.position
                    && rsp_data.match_start_pos <= rsp_data.position)
      else $error("match positions beyond position");
endmodule
